// ----- rtl/ratq_pkg.sv -----
// ----------------------------------------------------------------------------
// ratq_pkg
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ratq_pkg;

   localparam int ADC_BITS_DEF     = 12;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_BITS_DEF   = 16;
   localparam int MAX_STEPS        = 24;
   localparam int Z_BITS           = 32;

   localparam logic [2:0] REG_SINE_OFFSET = 3'd0;
   localparam logic [2:0] REG_COS_OFFSET  = 3'd1;
   localparam logic [2:0] REG_SINE_GAIN   = 3'd2;
   localparam logic [2:0] REG_COS_GAIN    = 3'd3;
   localparam logic [2:0] REG_COUNTS      = 3'd4;

   localparam logic [11:0] SINE_OFFSET_RST = 12'd1350;
   localparam logic [11:0] COS_OFFSET_RST  = 12'd1350;
   localparam logic [15:0] SINE_GAIN_RST   = 16'd839;
   localparam logic [15:0] COS_GAIN_RST    = 16'd839;
   localparam logic [12:0] COUNTS_RST      = 13'd500;

   typedef struct packed {
      logic [15:0] pos_index;
      logic [15:0] total;
   } scale_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/ratq_front.sv -----
// ----------------------------------------------------------------------------
// ratq_front
// Calibrates samples, holds the latest value per channel and pushes a
// sine/cosine pair into the queue once both channels are seen.
// ----------------------------------------------------------------------------
module ratq_front #(
   parameter int ADC_BITS = ratq_pkg::ADC_BITS_DEF,
   parameter int VAL_BITS = ADC_BITS + 17
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic                       in_channel,
   input  logic [ADC_BITS-1:0]        in_sample,
   input  logic [ADC_BITS-1:0]        sine_bias,
   input  logic [ADC_BITS-1:0]        cos_bias,
   input  logic [15:0]                sine_gain,
   input  logic [15:0]                cos_gain,
   output logic                       pair_valid,
   input  logic                       pair_ready,
   output logic signed [VAL_BITS-1:0] pair_sine,
   output logic signed [VAL_BITS-1:0] pair_cos
);

   logic                       busy_ff;
   logic                       chan_ff;
   logic signed [ADC_BITS:0]   diff_ff;
   logic [15:0]                gain_ff;
   logic signed [VAL_BITS-1:0] sine_ff, cos_ff, prod;
   logic                       sine_seen_ff, cos_seen_ff;
   logic                       q_valid_ff;
   logic signed [VAL_BITS-1:0] q_sine_ff, q_cos_ff;
   logic                       both;

   assign in_ready = !busy_ff && !q_valid_ff;
   assign prod = VAL_BITS'(diff_ff) * VAL_BITS'($signed({1'b0, gain_ff}));
   assign both = chan_ff ? sine_seen_ff : cos_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         sine_seen_ff <= 1'b0;
         cos_seen_ff  <= 1'b0;
         q_valid_ff   <= 1'b0;
         sine_ff      <= '0;
         cos_ff       <= '0;
      end else begin
         if (q_valid_ff && pair_ready) q_valid_ff <= 1'b0;
         if (in_valid && in_ready) begin
            busy_ff <= 1'b1;
            chan_ff <= in_channel;
            diff_ff <= in_channel
               ? $signed({1'b0, in_sample}) - $signed({1'b0, cos_bias})
               : $signed({1'b0, in_sample}) - $signed({1'b0, sine_bias});
            gain_ff <= in_channel ? cos_gain : sine_gain;
         end else if (busy_ff) begin
            busy_ff <= 1'b0;
            if (chan_ff) cos_ff <= prod;
            else         sine_ff <= prod;
            if (both) begin
               sine_seen_ff <= 1'b0;
               cos_seen_ff  <= 1'b0;
               q_valid_ff   <= 1'b1;
               q_sine_ff    <= chan_ff ? sine_ff : prod;
               q_cos_ff     <= chan_ff ? prod : cos_ff;
            end else if (chan_ff) begin
               cos_seen_ff <= 1'b1;
            end else begin
               sine_seen_ff <= 1'b1;
            end
         end
      end
   end

   assign pair_valid = q_valid_ff;
   assign pair_sine  = q_sine_ff;
   assign pair_cos   = q_cos_ff;

`ifndef SYNTHESIS
   a_seen_clear: assert property (@(posedge clock) disable iff (reset)
      $rose(q_valid_ff) |-> !sine_seen_ff && !cos_seen_ff)
      else $error("seen flags not cleared on pair push");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !in_ready) else $error("accept while calibrating");
   a_queue_hold: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff && !pair_ready |=> q_valid_ff && $stable(q_sine_ff))
      else $error("queue entry lost");
`endif

endmodule

// ----- rtl/ratq_back.sv -----
// ----------------------------------------------------------------------------
// ratq_back
// Iterative CORDIC atan2, quadrature scaling and a result register.
// ----------------------------------------------------------------------------
module ratq_back #(
   parameter int VAL_BITS     = 29,
   parameter int CORDIC_STEPS = ratq_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_BITS   = ratq_pkg::ANGLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pair_valid,
   output logic                       pair_ready,
   input  logic signed [VAL_BITS-1:0] pair_sine,
   input  logic signed [VAL_BITS-1:0] pair_cos,
   input  logic [12:0]                counts,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic                       out_a,
   output logic                       out_b,
   output logic                       out_z,
   output logic [14:0]                out_index,
   output logic [ANGLE_BITS-1:0]      out_angle
);

   localparam int XB = VAL_BITS + 2;
   localparam int SB = $clog2(CORDIC_STEPS + 1);
   localparam logic [1:0] ST_IDLE = 2'd0, ST_ITER = 2'd1, ST_SCALE = 2'd2,
                          ST_OUT = 2'd3;

   logic [1:0]              state_ff;
   logic [SB-1:0]           step_ff;
   logic signed [XB-1:0]    x_ff, y_ff, xs, ys;
   logic [31:0]             z_ff, zr;
   logic [ANGLE_BITS-1:0]   ang_ff;
   logic [15:0]             total_ff;
   logic [ANGLE_BITS+15:0]  prod;
   logic [15:0]             idx;
   logic                    r_valid_ff;
   ratq_pkg::scale_type     res_ff;

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign zr = z_ff + (32'd1 << (31 - ANGLE_BITS));
   assign prod = ang_ff * total_ff;
   assign idx = 16'(prod >> ANGLE_BITS) >= total_ff ? total_ff - 16'd1
                                                    : 16'(prod >> ANGLE_BITS);
   assign pair_ready = state_ff == ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         r_valid_ff <= 1'b0;
      end else begin
         if (r_valid_ff && out_ready) r_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (pair_valid) begin
               step_ff  <= '0;
               total_ff <= {1'b0, (counts == 13'd0 ? 13'd1 : counts), 2'b00};
               if (pair_cos < 0) begin
                  x_ff <= -XB'(pair_cos);
                  y_ff <= -XB'(pair_sine);
                  z_ff <= 32'h80000000;
               end else begin
                  x_ff <= XB'(pair_cos);
                  y_ff <= XB'(pair_sine);
                  z_ff <= 32'h0;
               end
               state_ff <= (pair_cos == 0 && pair_sine == 0) ? ST_SCALE : ST_ITER;
               ang_ff   <= '0;
            end
            ST_ITER: begin
               if (y_ff >= 0) begin
                  x_ff <= x_ff + ys; y_ff <= y_ff - xs;
                  z_ff <= z_ff + ratq_pkg::atan_entry(5'(step_ff));
               end else begin
                  x_ff <= x_ff - ys; y_ff <= y_ff + xs;
                  z_ff <= z_ff - ratq_pkg::atan_entry(5'(step_ff));
               end
               step_ff <= step_ff + SB'(1);
               if (step_ff == SB'(CORDIC_STEPS - 1)) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               ang_ff   <= zr[31 -: ANGLE_BITS];
               state_ff <= ST_SCALE;
            end
            ST_SCALE: if (!r_valid_ff) begin
               res_ff.pos_index <= idx;
               res_ff.total     <= total_ff;
               out_angle        <= ang_ff;
               r_valid_ff       <= 1'b1;
               state_ff         <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign out_valid = r_valid_ff;
   assign out_a     = res_ff.pos_index[0] ^ res_ff.pos_index[1];
   assign out_b     = res_ff.pos_index[1];
   assign out_z     = res_ff.pos_index[15:2] == 14'd0;
   assign out_index = res_ff.pos_index[14:0];

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      r_valid_ff |-> res_ff.pos_index < res_ff.total) else $error("index range");
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      r_valid_ff && !out_ready |=> r_valid_ff && $stable(res_ff))
      else $error("result lost");
   a_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ITER |-> step_ff < SB'(CORDIC_STEPS)) else $error("step");
`endif

endmodule

// ----- rtl/resolver_angle_to_quadrature_core.sv -----
// ----------------------------------------------------------------------------
// resolver_angle_to_quadrature_core
// Resolver sine/cosine samples to quadrature encoder position.
// ----------------------------------------------------------------------------
// channel | direction | tdata / content
// req     | in        | sample[11:0], tuser = channel
// rsp     | out       | a, b, z, index[14:0], angle[15:0]
// csr     | in        | index[2:0], data[15:0]
// A sample beat is captured and then calibrated in the front; in the back a pair
// runs the one-step-a-cycle CORDIC loop, a rounding state and a scaling state.
// Front and back stall independently through a one-entry queue.
// Reset is synchronous and restores register defaults, clears seen flags.
// ----------------------------------------------------------------------------
module resolver_angle_to_quadrature_core #(
   parameter int ADC_BITS     = ratq_pkg::ADC_BITS_DEF,
   parameter int CORDIC_STEPS = ratq_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_BITS   = ratq_pkg::ANGLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [((ADC_BITS+7)/8)*8-1:0] req_tdata,  // sample
   input  logic                     req_tuser,  // channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // enc_a, enc_b, enc_z, position_index[14:0], angle_turn
   output logic [((ANGLE_BITS+18+7)/8)*8-1:0] rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_data
);

   localparam int VAL_BITS = ADC_BITS + 17;
   localparam int RW = ((ANGLE_BITS + 18 + 7) / 8) * 8;

   logic [ADC_BITS-1:0] sine_off_ff, cos_off_ff;
   logic [15:0]         sine_gain_ff, cos_gain_ff;
   logic [12:0]         counts_ff;
   logic                pv, pr, a, b, z;
   logic signed [VAL_BITS-1:0] ps, pc;
   logic [14:0]         idx;
   logic [ANGLE_BITS-1:0] ang;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sine_off_ff  <= ADC_BITS'(ratq_pkg::SINE_OFFSET_RST);
         cos_off_ff   <= ADC_BITS'(ratq_pkg::COS_OFFSET_RST);
         sine_gain_ff <= ratq_pkg::SINE_GAIN_RST;
         cos_gain_ff  <= ratq_pkg::COS_GAIN_RST;
         counts_ff    <= ratq_pkg::COUNTS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            ratq_pkg::REG_SINE_OFFSET: sine_off_ff  <= ADC_BITS'(csr_data);
            ratq_pkg::REG_COS_OFFSET:  cos_off_ff   <= ADC_BITS'(csr_data);
            ratq_pkg::REG_SINE_GAIN:   sine_gain_ff <= csr_data;
            ratq_pkg::REG_COS_GAIN:    cos_gain_ff  <= csr_data;
            ratq_pkg::REG_COUNTS:      counts_ff    <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   ratq_front #(.ADC_BITS(ADC_BITS), .VAL_BITS(VAL_BITS)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_channel(req_tuser), .in_sample(req_tdata[ADC_BITS-1:0]),
      .sine_bias(sine_off_ff), .cos_bias(cos_off_ff),
      .sine_gain(sine_gain_ff), .cos_gain(cos_gain_ff),
      .pair_valid(pv), .pair_ready(pr), .pair_sine(ps), .pair_cos(pc));

   ratq_back #(.VAL_BITS(VAL_BITS), .CORDIC_STEPS(CORDIC_STEPS),
               .ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock, .reset, .pair_valid(pv), .pair_ready(pr), .pair_sine(ps),
      .pair_cos(pc), .counts(counts_ff), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_a(a), .out_b(b), .out_z(z),
      .out_index(idx), .out_angle(ang));

   assign rsp_tdata = RW'({ang, idx, z, b, a});

endmodule
